/* rtl/dpx_pkg.sv */
// Package: shared types and constants for the A64 data-processing execute block.
`default_nettype none
package dpx_pkg;
   localparam int unsigned RegCount = 31;
   localparam int unsigned ImmShift = 12;

   typedef enum logic [1:0] {
      SHIFT_LSL = 2'd0,
      SHIFT_LSR = 2'd1,
      SHIFT_ASR = 2'd2,
      SHIFT_ROR = 2'd3
   } shift_type;

   localparam logic [2:0] ImmClassAddSub = 3'b010;
   localparam logic [2:0] ImmClassMove   = 3'b101;
   localparam logic [1:0] MoveN = 2'b00;
   localparam logic [1:0] MoveInvalid = 2'b01;
   localparam logic [1:0] MoveZ = 2'b10;
   localparam logic [1:0] MoveK = 2'b11;
   localparam logic [1:0] LogAnd  = 2'b00;
   localparam logic [1:0] LogOrr  = 2'b01;
   localparam logic [1:0] LogEor  = 2'b10;
   localparam logic [1:0] LogAnds = 2'b11;

   typedef struct packed {
      logic        dest_write;
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
      logic        flags_written;
      logic [3:0]  nzcv;
   } result_type;
endpackage
`default_nettype wire

/* rtl/a64_data_processing_execute.sv */
// Top level: register file, flags, ALU and result register.
//
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_opcode, req_instruction_word
//  rsp     | out       | rsp_valid, rsp_stall, rsp_dest_*, rsp_flags_written, rsp_nzcv
//
// One item per cycle while the result is not stalled; a result appears in the cycle after acceptance.
// The register file and flags update at the accepting edge, so the next
// item reads them with no bubble (the combinational ALU path sets the rate).
// Reset clears all 31 registers and the flags at once (flip-flops).
// A stalled result holds; the input takes an item while the result slot
// is empty or being taken.
`default_nettype none
module a64_data_processing_execute (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [31:0] req_instruction_word,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_dest_write,
   output logic [4:0]       rsp_dest_index,
   output logic [63:0]      rsp_dest_value,
   output logic             rsp_flags_written,
   output logic [3:0]       rsp_nzcv
);
   import dpx_pkg::*;

   logic [63:0] regs_ff [RegCount];
   logic [3:0]  flags_ff;
   logic        valid_ff;
   result_type  res_ff, res_in;
   logic        take;

   function automatic logic [63:0] rd_reg(input logic [4:0] idx,
                                          input logic [63:0] r [RegCount]);
      return (idx == 5'd31) ? 64'd0 : r[idx];
   endfunction

   assign req_stall = valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   dpx_alu u_alu (
      .opcode (req_opcode),
      .word   (req_instruction_word),
      .rn_val (rd_reg(req_instruction_word[9:5], regs_ff)),
      .rm_val (rd_reg(req_instruction_word[20:16], regs_ff)),
      .ra_val (rd_reg(req_instruction_word[14:10], regs_ff)),
      .rd_val (rd_reg(req_instruction_word[4:0], regs_ff)),
      .flags  (flags_ff),
      .result (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         flags_ff <= '0;
         for (int i = 0; i < RegCount; i++) regs_ff[i] <= '0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            flags_ff <= res_in.nzcv;
            if (res_in.dest_write) regs_ff[res_in.dest_index] <= res_in.dest_value;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_dest_write    = res_ff.dest_write;
   assign rsp_dest_index    = res_ff.dest_index;
   assign rsp_dest_value    = res_ff.dest_value;
   assign rsp_flags_written = res_ff.flags_written;
   assign rsp_nzcv          = res_ff.nzcv;
endmodule
`default_nettype wire

/* rtl/dpx_alu.sv */
// Combinational datapath: decode, operand shaping, add/logic/move/multiply, flags.
`default_nettype none
module dpx_alu (
   input  wire logic        opcode,
   input  wire logic [31:0] word,
   input  wire logic [63:0] rn_val,
   input  wire logic [63:0] rm_val,
   input  wire logic [63:0] ra_val,
   input  wire logic [63:0] rd_val,
   input  wire logic [3:0]  flags,
   output dpx_pkg::result_type result
);
   import dpx_pkg::*;

   logic        sf;
   logic [63:0] mask, a, b, ra, op2, val, imm, sum, shifted, prod;
   logic [63:0] p_ll;
   logic [31:0] p_lh, p_hl;
   logic [5:0]  amt, pos;
   logic [1:0]  opc;
   logic        done, setf, addsub, sub, c, v, nf, zf;
   logic [64:0] sum_w;
   logic [32:0] sum_n;
   logic [127:0] rot_src;

   always_comb begin
      sf   = word[31];
      opc  = word[30:29];
      mask = sf ? '1 : 64'h0000_0000_FFFF_FFFF;
      a    = rn_val & mask;
      b    = rm_val & mask;
      ra   = ra_val & mask;
      amt  = sf ? word[15:10] : {1'b0, word[14:10]};
      pos  = {word[22:21], 4'd0};
      imm  = {48'd0, word[20:5]} << pos;
      // Register operand shifter.
      rot_src = sf ? {b, b} : {64'd0, b[31:0], b[31:0]};
      shifted = '0;
      case (shift_type'(word[23:22]))
         SHIFT_LSL: shifted = (b << amt) & mask;
         SHIFT_LSR: shifted = b >> amt;
         SHIFT_ASR: shifted = sf ? 64'($signed(b) >>> amt)
                                 : {32'd0, 32'($signed(b[31:0]) >>> amt[4:0])};
         default:   shifted = 64'(rot_src >> amt) & mask;
      endcase
      // Low 64 bits of the product from 32-bit partial products.
      p_ll = 64'(a[31:0]) * 64'(b[31:0]);
      p_lh = a[31:0] * b[63:32];
      p_hl = a[63:32] * b[31:0];
      prod = p_ll + {p_lh + p_hl, 32'd0};
      done = 1'b0; setf = 1'b0; addsub = 1'b0;
      op2 = '0; val = '0;
      if (!opcode) begin
         if (word[25:23] == ImmClassAddSub) begin
            op2 = {52'd0, word[21:10]};
            if (word[22]) op2 = op2 << ImmShift;
            addsub = 1'b1;
         end else if (word[25:23] == ImmClassMove && opc != MoveInvalid) begin
            case (opc)
               MoveN:   val = ~imm;
               MoveZ:   val = imm;
               MoveK:   val = ((rd_val & mask) & ~(64'hFFFF << pos)) | imm;
               default: val = '0;
            endcase
            val  = val & mask;
            done = 1'b1;
         end
      end else if (word[28]) begin
         val  = (word[15] ? ra - prod : ra + prod) & mask;
         done = 1'b1;
      end else begin
         op2 = shifted;
         if (word[24]) begin
            addsub = 1'b1;
         end else begin
            if (word[21]) op2 = ~op2 & mask;
            case (opc)
               LogAnd:  val = a & op2;
               LogOrr:  val = a | op2;
               LogEor:  val = a ^ op2;
               LogAnds: begin
                  val  = a & op2;
                  setf = 1'b1;
               end
            endcase
            done = 1'b1;
         end
      end
      sub   = opc[1];
      sum_w = {1'b0, a} + {1'b0, (sub ? ~op2 : op2) & mask} + {64'd0, sub};
      sum_n = {1'b0, a[31:0]} + {1'b0, sub ? ~op2[31:0] : op2[31:0]} + {32'd0, sub};
      sum   = sf ? sum_w[63:0] : {32'd0, sum_n[31:0]};
      c = 1'b0; v = 1'b0;
      if (addsub) begin
         setf = opc[0];
         val  = sum;
         done = 1'b1;
         c    = sf ? sum_w[64] : sum_n[32];
         v    = sf ? (a[63] == op2[63] ^ sub) && (sum[63] != a[63])
                   : (a[31] == op2[31] ^ sub) && (sum[31] != a[31]);
      end
      nf = sf ? val[63] : val[31];
      zf = (val == '0);
      result.dest_write    = done && (word[4:0] != 5'd31);
      result.dest_index    = word[4:0];
      result.dest_value    = done ? val : '0;
      result.flags_written = done && setf;
      result.nzcv          = (done && setf) ? {nf, zf, c, v} : flags;
   end
endmodule
`default_nettype wire

/* rtl/a64_data_processing_execute_checker.sv */
// Port-level checker for the execute block, bound to the top level.
`default_nettype none
module a64_data_processing_execute_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_dest_write,
   input wire logic [4:0]  rsp_dest_index,
   input wire logic [63:0] rsp_dest_value,
   input wire logic        rsp_flags_written
);
   // An accepted item shows a result next cycle.
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid) else $error("missing result");
   // No input stall without a waiting stalled result.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall) else $error("spurious stall");
   // Zero register is never written.
   a_zr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dest_write |-> rsp_dest_index != 5'd31)
      else $error("zero register write");
   // Stalled result holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_dest_value)
      && $stable(rsp_flags_written)) else $error("result changed under stall");
endmodule

bind a64_data_processing_execute a64_data_processing_execute_checker u_checker (.*);
`default_nettype wire
